### rtl/encoder_period_speed_meter_unit_macros.svh
// Assertion helpers shared by the speed meter RTL.
// Both sample on the rising edge of clock and are held off during reset.
`ifndef ENCODER_PERIOD_SPEED_METER_UNIT_MACROS_SVH
`define ENCODER_PERIOD_SPEED_METER_UNIT_MACROS_SVH

// Same-cycle implication.
`define EPSM_ASSERT_IMP(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("speed meter check failed");

// Next-cycle implication.
`define EPSM_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("speed meter check failed");

`endif

### rtl/epsm_pkg.sv
`default_nettype none
package epsm_pkg;

   // Default width of the free-running tick counter
   localparam int COUNT_WIDTH_DEF = 16;

   // Fixed field widths
   localparam int CAPTURE_WIDTH  = 16;
   localparam int PERIOD_WIDTH   = 16;
   localparam int SPEED_WIDTH    = 16;
   localparam int COEF_WIDTH     = 32;
   localparam int MODE_WIDTH     = 2;

   // Divider geometry: one quotient bit per step
   localparam int DIVIDEND_WIDTH = COEF_WIDTH;
   localparam int DIVISOR_WIDTH  = PERIOD_WIDTH;
   localparam int DIV_STEPS      = DIVIDEND_WIDTH;
   localparam int DIV_CNT_WIDTH  = $clog2(DIV_STEPS + 1);

   localparam logic [PERIOD_WIDTH-1:0] STOP_PERIOD = 16'hFFFF;
   localparam logic [SPEED_WIDTH-1:0]  SPEED_MAX   = 16'hFFFF;
   localparam logic [COEF_WIDTH-1:0]   COEF_RESET  = 32'd40000;

   // Item kinds
   localparam logic ACT_WRAP = 1'b0;
   localparam logic ACT_EDGE = 1'b1;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_NORMAL   = 2'd0,
      MODE_ONE_WRAP = 2'd1,
      MODE_STOPPED  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic                     action;
      logic [CAPTURE_WIDTH-1:0] captured_count;
   } req_type;

   typedef struct packed {
      logic [PERIOD_WIDTH-1:0] period_out;
      logic [SPEED_WIDTH-1:0]  speed;
      logic [MODE_WIDTH-1:0]   mode_out;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage
`default_nettype wire

### rtl/encoder_period_speed_meter_unit.sv
// Encoder period speed meter.
// req channel: one word per event, action 0 for a tick counter wrap and
// action 1 for an encoder edge carrying the captured tick count. Every word
// gives exactly one rsp word: the current period, the speed (coefficient
// divided by period, truncated, saturated to 65535) and the measuring mode.
// csr channel: writes the 32-bit speed coefficient; taken only while idle.
// Timing: one word at a time. After acceptance a bit-serial restoring divider
// produces the 32-bit quotient one bit per cycle; the result is registered
// into the speed register and then the output register, where rsp_valid
// rises, and the next word is accepted once the sequencer is back in idle.
// req_stall stays high while a word is in work.
// Stall: if rsp_stall holds the previous word, the finished result waits in
// the block until the output register frees, and req_stall stays high.
// Reset: mode stopped, period 65535, last capture 0, coefficient 40000,
// no rsp word pending.
`default_nettype none
`include "encoder_period_speed_meter_unit_macros.svh"
module encoder_period_speed_meter_unit #(
   parameter int COUNT_WIDTH = epsm_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire epsm_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output epsm_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [epsm_pkg::COEF_WIDTH-1:0]  csr_data
);
   import epsm_pkg::*;

   localparam int DIFF_WIDTH = (COUNT_WIDTH > PERIOD_WIDTH) ? COUNT_WIDTH : PERIOD_WIDTH;

   state_type                state_ff, state_in;
   mode_type                 mode_ff, mode_in;
   logic [COUNT_WIDTH-1:0]   last_ff, last_in;
   logic [PERIOD_WIDTH-1:0]  period_ff, period_in;
   logic [SPEED_WIDTH-1:0]   speed_ff;
   logic [COEF_WIDTH-1:0]    coef_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff;

   logic                     req_accept;
   logic                     rsp_free;
   logic                     div_start;
   logic                     speed_load;
   logic                     rsp_load;
   logic [COUNT_WIDTH-1:0]   now;
   logic [COUNT_WIDTH-1:0]   diff;
   logic [DIFF_WIDTH-1:0]    diff_ext;
   logic [PERIOD_WIDTH-1:0]  diff_sat;
   div_status_type           div_status;
   logic [SPEED_WIDTH-1:0]   div_quotient;

   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Modular capture difference, clamped to the stop value
   always_comb begin
      now      = COUNT_WIDTH'(req_data.captured_count);
      diff     = now - last_ff;
      diff_ext = DIFF_WIDTH'(diff);
      diff_sat = (diff_ext > DIFF_WIDTH'(STOP_PERIOD)) ? STOP_PERIOD
                                                      : diff_ext[PERIOD_WIDTH-1:0];
   end

   // Track mode and period for the accepted word
   always_comb begin
      mode_in   = mode_ff;
      period_in = period_ff;
      last_in   = last_ff;
      if (req_data.action == ACT_WRAP) begin
         unique case (mode_ff)
            MODE_NORMAL: mode_in = MODE_ONE_WRAP;
            MODE_ONE_WRAP: begin
               mode_in   = MODE_STOPPED;
               period_in = STOP_PERIOD;
            end
            default: mode_in = mode_ff;
         endcase
      end else begin
         unique case (mode_ff)
            MODE_NORMAL: period_in = diff_sat;
            MODE_ONE_WRAP: period_in = (now < last_ff) ? diff_sat : STOP_PERIOD;
            default: period_in = period_ff;
         endcase
         mode_in = MODE_NORMAL;
         last_in = now;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_status.done) state_in = ST_FLUSH;
         ST_FLUSH:  if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall  = 1'b1;
      csr_ready  = 1'b0;
      div_start  = 1'b0;
      speed_load = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            csr_ready = 1'b1;
            div_start = req_valid;
         end
         ST_DIVIDE: speed_load = div_status.done;
         ST_FLUSH:  rsp_load   = rsp_free;
         default:   req_stall  = 1'b1;
      endcase
   end

   // Hold or drop the output word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_STOPPED;
         last_ff      <= '0;
         period_ff    <= STOP_PERIOD;
         coef_ff      <= COEF_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            mode_ff   <= mode_in;
            last_ff   <= last_in;
            period_ff <= period_in;
         end
         if (csr_valid && csr_ready) begin
            coef_ff <= csr_data;
         end
      end
      if (speed_load) begin
         speed_ff <= div_quotient;
      end
      if (rsp_load) begin
         rsp_data_ff.period_out <= period_ff;
         rsp_data_ff.speed      <= speed_ff;
         rsp_data_ff.mode_out   <= mode_ff;
      end
   end

   epsm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (coef_ff),
      .divisor  (period_in),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted word always launches the divider
   `EPSM_ASSERT_NEXT(a_accept_starts_div, req_accept, div_status.busy)
   // The divider only finishes while the sequencer waits for it
   `EPSM_ASSERT_IMP(a_done_in_divide, div_status.done, state_ff == ST_DIVIDE)
   // A taken word is not shown again unless a new one is loaded
   `EPSM_ASSERT_NEXT(a_no_repeat, rsp_valid_ff && !rsp_stall && state_ff != ST_FLUSH,
                     !rsp_valid_ff)

endmodule
`default_nettype wire

### rtl/epsm_divider.sv
`default_nettype none
module epsm_divider (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [epsm_pkg::DIVIDEND_WIDTH-1:0]  dividend,
   input  wire logic [epsm_pkg::DIVISOR_WIDTH-1:0]   divisor,
   output epsm_pkg::div_status_type                  status,
   output logic      [epsm_pkg::SPEED_WIDTH-1:0]     quotient
);
   import epsm_pkg::*;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [DIV_CNT_WIDTH-1:0]  count_ff, count_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_WIDTH-1:0] quo_ff, quo_in;
   logic [DIVISOR_WIDTH-1:0]  div_ff, div_in;
   logic [DIVISOR_WIDTH:0]    trial;
   logic [DIVISOR_WIDTH:0]    diff;
   logic                      fits;

   // Restoring step: shift in next dividend bit, subtract if it fits.
   // A zero divisor always fits, so the quotient comes out all ones.
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_WIDTH-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = (trial >= {1'b0, div_ff});
   end

   // Sequence the steps
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = DIV_CNT_WIDTH'(DIV_STEPS);
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
         quo_in   = {quo_ff[DIVIDEND_WIDTH-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   // Saturate quotients that do not fit the speed field
   assign quotient    = (|quo_ff[DIVIDEND_WIDTH-1:SPEED_WIDTH]) ? SPEED_MAX
                                                               : quo_ff[SPEED_WIDTH-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
`default_nettype wire

### sim/tb_encoder_period_speed_meter_unit.sv
`timescale 1ns / 1ps
module tb_encoder_period_speed_meter_unit;
   import epsm_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int TAIL_CYCLES  = 80;
   localparam int RANDOM_WORDS = 130;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COEF_WIDTH-1:0] csr_data  = '0;

   encoder_period_speed_meter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 8 ns clock
   initial forever #4 clock = ~clock;

   // words waiting to go out, readings waiting to come back
   req_type pending_words[$];
   rsp_type expected_readings[$];

   // meter copy used to predict readings
   logic [COEF_WIDTH-1:0]    meter_coef   = COEF_RESET;
   logic [CAPTURE_WIDTH-1:0] meter_last   = '0;
   mode_type                 meter_mode   = MODE_STOPPED;
   logic [PERIOD_WIDTH-1:0]  meter_period = STOP_PERIOD;

   // tick counter position used to build plausible edge sequences
   logic [CAPTURE_WIDTH-1:0] tick_phase = '0;

   // idle control: odds out of 100 that a free cycle starts a burst
   bit idling_on  = 1'b1;
   int send_odds  = 10;
   int stall_odds = 10;
   int send_gap   = 0;
   int stall_left = 0;

   int error_count    = 0;
   int words_sent     = 0;
   int readings_seen  = 0;
   int coef_settings  = 1;
   int cycle_count    = 0;

   // advance the meter by one word and return the reading it should give
   function automatic rsp_type predict_reading(input req_type w);
      rsp_type                 r;
      logic [PERIOD_WIDTH-1:0] gap;
      logic [COEF_WIDTH-1:0]   quot;
      gap = w.captured_count - meter_last;
      if (w.action == ACT_WRAP) begin
         case (meter_mode)
            MODE_NORMAL: meter_mode = MODE_ONE_WRAP;
            MODE_ONE_WRAP: begin
               meter_period = STOP_PERIOD;
               meter_mode   = MODE_STOPPED;
            end
            default: ;
         endcase
      end else begin
         case (meter_mode)
            MODE_NORMAL: meter_period = gap;
            MODE_ONE_WRAP: meter_period = (w.captured_count < meter_last) ? gap : STOP_PERIOD;
            default: ;
         endcase
         meter_mode = MODE_NORMAL;
         meter_last = w.captured_count;
      end
      r.period_out = meter_period;
      if (meter_period == '0) begin
         r.speed = SPEED_MAX;
      end else begin
         quot = meter_coef / {16'd0, meter_period};
         r.speed = (quot > {16'd0, SPEED_MAX}) ? SPEED_MAX : quot[SPEED_WIDTH-1:0];
      end
      r.mode_out = meter_mode;
      return r;
   endfunction

   task automatic queue_word(input logic act, input logic [CAPTURE_WIDTH-1:0] cnt);
      req_type w;
      w.action         = act;
      w.captured_count = cnt;
      pending_words.push_back(w);
   endtask

   // corner sequence: stop handling, zero and unit periods, wrap rules
   task automatic queue_corner_words();
      queue_word(ACT_WRAP, 16'hFFFF);   // wrap while stopped
      queue_word(ACT_EDGE, 16'h0000);   // leave stopped, period kept
      queue_word(ACT_EDGE, 16'h0000);   // zero period
      queue_word(ACT_EDGE, 16'h0001);   // period 1, large quotient
      queue_word(ACT_EDGE, 16'hFFFF);
      queue_word(ACT_EDGE, 16'h0000);   // modular difference
      queue_word(ACT_WRAP, 16'h0000);
      queue_word(ACT_EDGE, 16'h0000);   // equal capture after one wrap
      queue_word(ACT_EDGE, 16'h8000);
      queue_word(ACT_WRAP, 16'h1234);
      queue_word(ACT_EDGE, 16'h1000);   // lower capture after one wrap
      queue_word(ACT_WRAP, 16'h0000);
      queue_word(ACT_WRAP, 16'h0000);   // second wrap stops
      queue_word(ACT_WRAP, 16'hFFFF);   // wrap while stopped
      queue_word(ACT_EDGE, 16'h5555);
      queue_word(ACT_EDGE, 16'hAAAA);
      queue_word(ACT_WRAP, 16'hAAAA);
      queue_word(ACT_EDGE, 16'hFFFF);   // higher capture after one wrap
      queue_word(ACT_EDGE, 16'hFFFF);
      queue_word(ACT_EDGE, 16'hFFFE);   // largest difference
      tick_phase = 16'hFFFE;
   endtask

   // mostly edges that follow a running tick counter, with wraps where it
   // rolls over; some words are random noise
   task automatic queue_random_words(input int count);
      int          made;
      int unsigned pick;
      int unsigned delta;
      int unsigned reach;
      int unsigned wraps;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            queue_word(1'($urandom_range(0, 1)), 16'($urandom));
            made++;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 20)      delta = $urandom_range(0, 15);
            else if (pick < 60) delta = $urandom_range(16, 4000);
            else if (pick < 85) delta = $urandom_range(4001, 65535);
            else if (pick < 95) delta = $urandom_range(65536, 131071);
            else                delta = $urandom_range(131072, 200000);
            reach = {16'd0, tick_phase} + delta;
            wraps = reach >> 16;
            repeat (wraps) queue_word(ACT_WRAP, 16'($urandom));
            tick_phase = reach[15:0];
            queue_word(ACT_EDGE, tick_phase);
            made += wraps + 1;
         end
      end
   endtask

   // wait until nothing is queued, in flight or owed; look between edges
   // so the driver and monitor have settled
   task automatic wait_for_idle();
      while (pending_words.size() != 0 || req_valid || expected_readings.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_coefficient(input logic [COEF_WIDTH-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      meter_coef = value;
      coef_settings++;
   endtask

   // request driver: log the word taken at this edge, then offer the next
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            expected_readings.push_back(predict_reading(req_data));
            words_sent++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            if (idling_on && $urandom_range(0, 99) < send_odds) begin
               send_gap = $urandom_range(0, 14);
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data  <= pending_words.pop_front();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor: check each taken reading, then pick the next stall
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            readings_seen++;
            if (expected_readings.size() == 0) begin
               error_count++;
               $display("%0t: unexpected reading: expected none, got period %0d speed %0d mode %0d",
                        $realtime, rsp_data.period_out, rsp_data.speed, rsp_data.mode_out);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_data.period_out !== want.period_out || rsp_data.speed !== want.speed ||
                   rsp_data.mode_out !== want.mode_out) begin
                  error_count++;
                  $display("%0t: reading mismatch: expected period %0d speed %0d mode %0d, got period %0d speed %0d mode %0d",
                           $realtime, want.period_out, want.speed, want.mode_out,
                           rsp_data.period_out, rsp_data.speed, rsp_data.mode_out);
               end
            end
         end
         if (!idling_on) begin
            stall_left = 0;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 99) < stall_odds) begin
            stall_left = $urandom_range(0, 14);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // hard stop
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d readings owed",
                  cycle_count, expected_readings.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [COEF_WIDTH-1:0] coef_plan [0:4];
      int                    odds_plan [0:4];
      int                    phase;
      coef_plan[0] = 32'd1;
      coef_plan[1] = 32'hFFFF_FFFF;
      coef_plan[2] = 32'd65535;
      coef_plan[3] = ($urandom == 0) ? 32'd1 : 32'($urandom);
      coef_plan[4] = COEF_RESET;
      odds_plan[0] = 40;
      odds_plan[1] = 8;
      odds_plan[2] = 60;
      odds_plan[3] = 20;
      odds_plan[4] = 0;

      // hold reset, then release it
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // corner words at the reset coefficient
      queue_corner_words();
      wait_for_idle();

      // random traffic at each coefficient; the last run has no idling
      for (phase = 0; phase < 5; phase++) begin
         write_coefficient(coef_plan[phase]);
         send_odds  = odds_plan[phase];
         stall_odds = odds_plan[phase];
         idling_on  = (phase != 4);
         queue_random_words(RANDOM_WORDS);
         wait_for_idle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_readings.size() != 0) begin
         error_count++;
         $display("%0t: %0d readings never arrived", $realtime, expected_readings.size());
      end

      $display("Sent %0d words and checked %0d readings across %0d speed coefficients,",
               words_sent, readings_seen, coef_settings);
      $display("including stop, wrap and saturation cases; %0d errors.", error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/epsm_pkg.sv
rtl/epsm_divider.sv
rtl/encoder_period_speed_meter_unit.sv
sim/tb_encoder_period_speed_meter_unit.sv
